// ===== rtl/core/mvsm_pkg.sv =====
`default_nettype none
package mvsm_pkg;
   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_DEFINE = 3'd1,
      OP_PLAY = 3'd2,
      OP_STOP = 3'd3,
      OP_MIX = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_ACCUM,
      ST_DONE
   } state_type;

   localparam int SampleWidth = 16;
   localparam int GainWidth = 7;
   localparam int LengthWidth = 17;
   localparam int PosWidth = 16;
   localparam int AccWidth = 24;
   localparam int SatMax = 32767;
   localparam int PercentScale = 100;
   localparam int MagWidth = 24;
   localparam int RecipShift = 29;
   localparam int RecipMul = ((1 << RecipShift) + PercentScale - 1) / PercentScale;

   typedef struct packed {
      logic mix_begin;
      logic voice_next;
      logic voice_read;
      logic voice_accum;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic voice_busy;
      logic last_voice;
   } stat_type;
endpackage
`default_nettype wire

// ===== rtl/core/mvsm_ram.sv =====
`default_nettype none
module mvsm_ram #(
   parameter int Width = 32,
   parameter int Depth = 65536
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] wr_addr,
   input wire logic [Width-1:0] wr_data,
   input wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/mvsm_ctrl.sv =====
`default_nettype none
module mvsm_ctrl
   import mvsm_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic go_mix,
   input wire stat_type stat,
   output cmd_type cmd,
   output logic busy
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (go_mix) begin
               cmd.mix_begin = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.voice_busy) begin
               cmd.voice_read = 1'b1;
               state_in = ST_READ;
            end else if (stat.last_voice) begin
               state_in = ST_DONE;
            end else begin
               cmd.voice_next = 1'b1;
            end
         end
         ST_READ: state_in = ST_ACCUM;
         ST_ACCUM: begin
            cmd.voice_accum = 1'b1;
            if (stat.last_voice) begin
               state_in = ST_DONE;
            end else begin
               cmd.voice_next = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/core/mvsm_dp.sv =====
`default_nettype none
module mvsm_dp
   import mvsm_pkg::*;
#(
   parameter int VoiceSlots = 8,
   parameter int ClipEntries = 16,
   parameter int SampleFrames = 65536
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire logic [2:0] req_operation,
   input wire logic [15:0] req_sample_address,
   input wire logic signed [15:0] req_left_sample,
   input wire logic signed [15:0] req_right_sample,
   input wire logic [3:0] req_clip_index,
   input wire logic [15:0] req_clip_start,
   input wire logic [16:0] req_clip_length,
   input wire logic req_loop_enable,
   input wire logic [6:0] req_left_volume,
   input wire logic [6:0] req_right_volume,
   input wire cmd_type cmd,
   output stat_type stat,
   output logic rsp_valid,
   output logic signed [15:0] rsp_left_out,
   output logic signed [15:0] rsp_right_out,
   output logic [3:0] rsp_voices_mixed
);
   localparam int AW = $clog2(SampleFrames);
   localparam int VW = (VoiceSlots > 1) ? $clog2(VoiceSlots) : 1;
   localparam int CW = (ClipEntries > 1) ? $clog2(ClipEntries) : 1;
   localparam logic [2*MagWidth-1:0] RecipMulW = (2*MagWidth)'(RecipMul);

   logic [VoiceSlots-1:0] vbusy_ff;
   logic [3:0] vclip_ff [VoiceSlots];
   logic [PosWidth-1:0] pos_ff [ClipEntries];
   logic [15:0] cstart_ff [ClipEntries];
   logic [LengthWidth-1:0] clen_ff [ClipEntries];
   logic cloop_ff [ClipEntries];
   logic [2*GainWidth-1:0] cgain_ff [ClipEntries];

   logic [VW-1:0] vidx_ff;
   logic [CW-1:0] cur_ff;
   logic signed [AccWidth-1:0] lacc_ff, racc_ff;
   logic [3:0] count_ff;
   logic [AW-1:0] rd_addr;
   logic [31:0] rd_data;
   logic [SampleWidth:0] labs, rabs;
   logic [MagWidth-1:0] lmag_ff, rmag_ff;
   logic lneg_ff, rneg_ff;
   logic [2*MagWidth-1:0] lrecip, rrecip;
   logic [AccWidth-1:0] lq, rq;
   logic signed [AccWidth-1:0] lsum, rsum;
   logic [LengthWidth-1:0] next_pos;
   logic clip_ok;
   logic [CW-1:0] req_c;
   logic [CW-1:0] vc;

   assign clip_ok = ({28'd0, req_clip_index} < 32'(ClipEntries));
   assign req_c = CW'(req_clip_index);
   assign vc = CW'(vclip_ff[vidx_ff]);
   assign stat.voice_busy = vbusy_ff[vidx_ff];
   assign stat.last_voice = (32'(vidx_ff) == VoiceSlots - 1);
   assign rd_addr = AW'({16'd0, cstart_ff[vc]} + {16'd0, pos_ff[vc]});
   assign next_pos = {1'b0, pos_ff[cur_ff]} + 1'b1;

   mvsm_ram #(.Width(32), .Depth(SampleFrames)) u_samples (
      .clock(clock),
      .wr_en(accept && req_operation == OP_WRITE),
      .wr_addr(AW'(req_sample_address)),
      .wr_data({req_right_sample, req_left_sample}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // scale the sample magnitude, keep the sign aside
   assign labs = rd_data[15] ? (17'd0 - {1'b1, rd_data[15:0]}) : {1'b0, rd_data[15:0]};
   assign rabs = rd_data[31] ? (17'd0 - {1'b1, rd_data[31:16]}) : {1'b0, rd_data[31:16]};

   // divide the magnitude by 100 with a reciprocal multiply, exact below 2^22
   assign lrecip = {{MagWidth{1'b0}}, lmag_ff} * RecipMulW;
   assign rrecip = {{MagWidth{1'b0}}, rmag_ff} * RecipMulW;
   assign lq = AccWidth'(lrecip[2*MagWidth-1:RecipShift]);
   assign rq = AccWidth'(rrecip[2*MagWidth-1:RecipShift]);
   assign lsum = lneg_ff ? (lacc_ff - $signed(lq)) : (lacc_ff + $signed(lq));
   assign rsum = rneg_ff ? (racc_ff - $signed(rq)) : (racc_ff + $signed(rq));

   always_ff @(posedge clock) begin
      if (cmd.voice_read) begin
         cur_ff <= vc;
      end
      // multiply on the cycle the RAM data arrives
      lmag_ff <= {{(MagWidth-SampleWidth-1){1'b0}}, labs} *
                 {{(MagWidth-GainWidth){1'b0}}, cgain_ff[cur_ff][6:0]};
      rmag_ff <= {{(MagWidth-SampleWidth-1){1'b0}}, rabs} *
                 {{(MagWidth-GainWidth){1'b0}}, cgain_ff[cur_ff][13:7]};
      lneg_ff <= rd_data[15];
      rneg_ff <= rd_data[31];
      if (accept && clip_ok && req_operation == OP_DEFINE) begin
         cstart_ff[req_c] <= req_clip_start;
         clen_ff[req_c] <= req_clip_length;
         cloop_ff[req_c] <= req_loop_enable;
         cgain_ff[req_c] <= {req_right_volume, req_left_volume};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vbusy_ff <= '0;
         for (int i = 0; i < VoiceSlots; i++) vclip_ff[i] <= '0;
         for (int i = 0; i < ClipEntries; i++) pos_ff[i] <= '0;
         vidx_ff <= '0;
         lacc_ff <= '0;
         racc_ff <= '0;
         count_ff <= '0;
         rsp_valid <= 1'b0;
         rsp_left_out <= '0;
         rsp_right_out <= '0;
         rsp_voices_mixed <= '0;
      end else begin
         rsp_valid <= 1'b0;
         if (accept && clip_ok) begin
            case (req_operation)
               OP_DEFINE: pos_ff[req_c] <= '0;
               OP_PLAY: begin : play_pick
                  logic found;
                  found = 1'b0;
                  for (int i = 0; i < VoiceSlots; i++) begin
                     if (!found && (!vbusy_ff[i] || vclip_ff[i] == req_clip_index)) begin
                        found = 1'b1;
                        vbusy_ff[i] <= 1'b1;
                        vclip_ff[i] <= req_clip_index;
                     end
                  end
               end
               OP_STOP: begin : stop_pick
                  logic found;
                  found = 1'b0;
                  for (int i = 0; i < VoiceSlots; i++) begin
                     if (!found && vbusy_ff[i] && vclip_ff[i] == req_clip_index) begin
                        found = 1'b1;
                        vbusy_ff[i] <= 1'b0;
                        pos_ff[req_c] <= '0;
                     end
                  end
               end
               default: ;
            endcase
         end
         if (cmd.mix_begin) begin
            vidx_ff <= '0;
            lacc_ff <= '0;
            racc_ff <= '0;
            count_ff <= '0;
         end
         if (cmd.voice_next) begin
            vidx_ff <= vidx_ff + 1'b1;
         end
         if (cmd.voice_accum) begin
            lacc_ff <= lsum;
            racc_ff <= rsum;
            count_ff <= count_ff + 1'b1;
            if (next_pos == clen_ff[cur_ff]) begin
               pos_ff[cur_ff] <= '0;
               if (!cloop_ff[cur_ff]) vbusy_ff[vidx_ff] <= 1'b0;
            end else begin
               pos_ff[cur_ff] <= next_pos[PosWidth-1:0];
            end
         end
         if (cmd.finish) begin
            rsp_valid <= 1'b1;
            rsp_voices_mixed <= count_ff;
            rsp_left_out <= (lacc_ff > AccWidth'(SatMax)) ? 16'(SatMax) :
                            (lacc_ff < -AccWidth'(SatMax)) ? -16'(SatMax) : lacc_ff[15:0];
            rsp_right_out <= (racc_ff > AccWidth'(SatMax)) ? 16'(SatMax) :
                             (racc_ff < -AccWidth'(SatMax)) ? -16'(SatMax) : racc_ff[15:0];
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/multi_voice_sample_mixer_core.sv =====
// channel  | ports                        | handshake
// request  | req_*                        | start high and busy low
// result   | rsp_*                        | rsp_valid for one cycle
// Write, define, play and stop do not raise busy. A mix holds busy during the
// walk over the voice slots, with one sample RAM read per busy voice; rsp_valid
// rises in the first cycle with busy low, when a new request may already be
// accepted.
// The result receiver cannot stall.
// Reset clears voices and clip positions; sample and clip stores stay as written.
`default_nettype none
module multi_voice_sample_mixer_core
   import mvsm_pkg::*;
#(
   parameter int VOICE_SLOTS = 8,
   parameter int CLIP_ENTRIES = 16,
   parameter int SAMPLE_FRAMES = 65536
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic [2:0] req_operation,
   input wire logic [15:0] req_sample_address,
   input wire logic signed [15:0] req_left_sample,
   input wire logic signed [15:0] req_right_sample,
   input wire logic [3:0] req_clip_index,
   input wire logic [15:0] req_clip_start,
   input wire logic [16:0] req_clip_length,
   input wire logic req_loop_enable,
   input wire logic [6:0] req_left_volume,
   input wire logic [6:0] req_right_volume,
   output logic rsp_valid,
   output logic signed [15:0] rsp_left_out,
   output logic signed [15:0] rsp_right_out,
   output logic [3:0] rsp_voices_mixed
);
   cmd_type cmd;
   stat_type stat;
   logic accept;

   assign accept = start && !busy;

   mvsm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .go_mix(accept && req_operation == OP_MIX),
      .stat(stat), .cmd(cmd), .busy(busy)
   );

   mvsm_dp #(.VoiceSlots(VOICE_SLOTS), .ClipEntries(CLIP_ENTRIES),
             .SampleFrames(SAMPLE_FRAMES)) u_dp (
      .clock(clock), .reset(reset), .accept(accept),
      .req_operation(req_operation), .req_sample_address(req_sample_address),
      .req_left_sample(req_left_sample), .req_right_sample(req_right_sample),
      .req_clip_index(req_clip_index), .req_clip_start(req_clip_start),
      .req_clip_length(req_clip_length), .req_loop_enable(req_loop_enable),
      .req_left_volume(req_left_volume), .req_right_volume(req_right_volume),
      .cmd(cmd), .stat(stat), .rsp_valid(rsp_valid),
      .rsp_left_out(rsp_left_out), .rsp_right_out(rsp_right_out),
      .rsp_voices_mixed(rsp_voices_mixed)
   );
endmodule
`default_nettype wire
